>>> hw/rtl/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// shared constants, types and single-precision helpers for the slab test
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int FLT_W      = 32;
    localparam int NUM_AXES   = 3;
    localparam int IN_FIELDS  = 12;
    localparam int IN_W       = IN_FIELDS * FLT_W;

    // adder: align, add, normalise, round
    localparam int ADD_LAT    = 4;
    // divider: unpack, pre-scale, iterations, denormal shift, round
    localparam int DIV_QBITS  = 26;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STG    = DIV_QBITS / DIV_BITS;
    localparam int DIV_LAT    = DIV_STG + 4;

    localparam logic [31:0] QNAN_BIT  = 32'h0040_0000;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] DEF_NAN   = 32'hFFC0_0000;
    localparam logic [30:0] INF_MAG   = 31'h7F80_0000;
    localparam logic [31:0] MISS_VAL  = 32'hBF80_0000;
    localparam logic [31:0] POS_ZERO  = 32'h0000_0000;

    typedef logic signed [10:0] exp_t;

    function automatic logic f_is_nan(logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic f_is_inf(logic [31:0] x);
        return x[30:0] == INF_MAG;
    endfunction

    function automatic logic f_is_zero(logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    // monotonic ordering key
    function automatic logic [31:0] f_key(logic [31:0] x);
        return x[31] ? ~x : {1'b1, x[30:0]};
    endfunction

    function automatic logic f_lt(logic [31:0] a, logic [31:0] b);
        logic r;
        r = 1'b0;
        if (!f_is_nan(a) && !f_is_nan(b) && !(f_is_zero(a) && f_is_zero(b))) begin
            r = f_key(a) < f_key(b);
        end
        return r;
    endfunction

    // minimum ignoring a nan operand, -0 below +0
    function automatic logic [31:0] f_min(logic [31:0] a, logic [31:0] b);
        logic [31:0] r;
        if (f_is_nan(a)) begin
            r = b;
        end else if (f_is_nan(b)) begin
            r = a;
        end else if (f_is_zero(a) && f_is_zero(b)) begin
            r = a[31] ? a : b;
        end else begin
            r = f_lt(a, b) ? a : b;
        end
        return r;
    endfunction

    function automatic logic [31:0] f_max(logic [31:0] a, logic [31:0] b);
        logic [31:0] r;
        if (f_is_nan(a)) begin
            r = b;
        end else if (f_is_nan(b)) begin
            r = a;
        end else if (f_is_zero(a) && f_is_zero(b)) begin
            r = a[31] ? b : a;
        end else begin
            r = f_lt(b, a) ? a : b;
        end
        return r;
    endfunction

    function automatic logic [4:0] f_lzc27(logic [26:0] x);
        logic [4:0] c;
        c = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (x[i]) c = 5'(26 - i);
        end
        return c;
    endfunction

    function automatic logic [4:0] f_lzc24(logic [23:0] x);
        logic [4:0] c;
        c = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (x[i]) c = 5'(23 - i);
        end
        return c;
    endfunction

    // round to nearest even and pack; n holds mantissa in [26:3], guard and sticky below
    function automatic logic [31:0] f_round_pack(logic s, exp_t e, logic [26:0] n);
        logic [24:0] m;
        logic        rnd;
        exp_t        e2;
        logic [31:0] r;
        rnd = n[2] & (n[1] | n[0] | n[3]);
        m   = {1'b0, n[26:3]} + {24'd0, rnd};
        e2  = e;
        if (m[24]) begin
            m  = m >> 1;
            e2 = e + 11'sd1;
        end
        if (e2 >= 11'sd255) begin
            r = {s, INF_MAG};
        end else begin
            r = {s, (m[23] ? e2[7:0] : 8'd0), m[22:0]};
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/rbsi_fadd.sv
// ----------------------------------------------------------------------------
// rbsi_fadd
// four-stage single-precision adder / subtractor, round to nearest even
// ----------------------------------------------------------------------------
module rbsi_fadd (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic        sub,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        out_valid,
    output logic [31:0] y
);
    import rbsi_pkg::*;

    // stage a: specials and alignment
    logic        sb;
    logic        a_big;
    logic [7:0]  ea_eff, eb_eff, ebig, esml, dexp;
    logic [23:0] mbig, msml;
    logic [26:0] xs0, xmask, xs_al;
    logic        spec_next;
    logic [31:0] specv_next;

    always_comb begin
        sb     = b[31] ^ sub;
        ea_eff = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb_eff = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        a_big  = a[30:0] >= b[30:0];
        ebig   = a_big ? ea_eff : eb_eff;
        esml   = a_big ? eb_eff : ea_eff;
        mbig   = a_big ? {a[30:23] != 8'd0, a[22:0]} : {b[30:23] != 8'd0, b[22:0]};
        msml   = a_big ? {b[30:23] != 8'd0, b[22:0]} : {a[30:23] != 8'd0, a[22:0]};
        dexp   = ebig - esml;
        xs0    = {msml, 3'b000};
        if (dexp >= 8'd27) begin
            xmask = '1;
            xs_al = {26'd0, |xs0};
        end else begin
            xmask = (27'd1 << dexp[4:0]) - 27'd1;
            xs_al = (xs0 >> dexp[4:0]) | {26'd0, |(xs0 & xmask)};
        end
        spec_next  = 1'b1;
        specv_next = POS_ZERO;
        if (f_is_nan(a)) begin
            specv_next = a | QNAN_BIT;
        end else if (f_is_nan(b)) begin
            specv_next = b | QNAN_BIT;
        end else if (f_is_inf(a) && f_is_inf(b) && (a[31] != sb)) begin
            specv_next = DEF_NAN;
        end else if (f_is_inf(a)) begin
            specv_next = a;
        end else if (f_is_inf(b)) begin
            specv_next = {sb, b[30:0]};
        end else begin
            spec_next = 1'b0;
        end
    end

    logic        va_reg, vb_reg, vc_reg, vd_reg;
    logic        speca_reg, specb_reg, specc_reg;
    logic [31:0] specva_reg, specvb_reg, specvc_reg;
    logic        sgna_reg, sgnb_reg, sgnc_reg;
    logic        zsa_reg, zsb_reg;
    logic        suba_reg;
    logic [7:0]  ea_reg, eb_reg;
    logic [26:0] xa_reg, xs_reg;
    logic [27:0] sum_reg;
    logic [26:0] nc_reg;
    exp_t        ec_reg;
    logic [31:0] y_reg;

    // stage c: normalise
    logic [4:0]  lz, sh;
    logic [7:0]  maxsh;
    logic [26:0] n_next;
    exp_t        e_next;

    always_comb begin
        lz    = f_lzc27(sum_reg[26:0]);
        maxsh = eb_reg - 8'd1;
        sh    = ({3'd0, lz} <= maxsh) ? lz : maxsh[4:0];
        if (sum_reg[27]) begin
            n_next = {sum_reg[27:2], |sum_reg[1:0]};
            e_next = exp_t'({3'd0, eb_reg}) + 11'sd1;
        end else begin
            n_next = sum_reg[26:0] << sh;
            e_next = exp_t'({3'd0, eb_reg}) - exp_t'({6'd0, sh});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            speca_reg  <= spec_next;
            specva_reg <= specv_next;
            sgna_reg   <= a_big ? a[31] : sb;
            zsa_reg    <= a[31] & sb;
            suba_reg   <= a[31] ^ sb;
            ea_reg     <= ebig;
            xa_reg     <= {mbig, 3'b000};
            xs_reg     <= xs_al;

            specb_reg  <= speca_reg;
            specvb_reg <= specva_reg;
            sgnb_reg   <= sgna_reg;
            zsb_reg    <= zsa_reg;
            eb_reg     <= ea_reg;
            sum_reg    <= suba_reg ? ({1'b0, xa_reg} - {1'b0, xs_reg})
                                   : ({1'b0, xa_reg} + {1'b0, xs_reg});

            specc_reg  <= specb_reg;
            specvc_reg <= specvb_reg;
            sgnc_reg   <= (sum_reg == 28'd0) ? zsb_reg : sgnb_reg;
            nc_reg     <= n_next;
            ec_reg     <= e_next;

            y_reg      <= specc_reg ? specvc_reg : f_round_pack(sgnc_reg, ec_reg, nc_reg);
        end
    end

    assign out_valid = vd_reg;
    assign y         = y_reg;

endmodule

>>> hw/rtl/rbsi_fdiv.sv
// ----------------------------------------------------------------------------
// rbsi_fdiv
// pipelined single-precision divider, restoring, two quotient bits a stage
// ----------------------------------------------------------------------------
module rbsi_fdiv (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] n,
    input  logic [31:0] d,
    output logic        out_valid,
    output logic [31:0] q
);
    import rbsi_pkg::*;

    // unpack: specials and mantissa normalisation
    logic        sq;
    logic [23:0] mn, md;
    logic [4:0]  lzn, lzd;
    exp_t        expn, expd;
    logic        spec_next;
    logic [31:0] specv_next;

    always_comb begin
        sq   = n[31] ^ d[31];
        mn   = {n[30:23] != 8'd0, n[22:0]};
        md   = {d[30:23] != 8'd0, d[22:0]};
        lzn  = f_lzc24(mn);
        lzd  = f_lzc24(md);
        expn = exp_t'({3'd0, (n[30:23] == 8'd0) ? 8'd1 : n[30:23]}) - exp_t'({6'd0, lzn});
        expd = exp_t'({3'd0, (d[30:23] == 8'd0) ? 8'd1 : d[30:23]}) - exp_t'({6'd0, lzd});
        spec_next  = 1'b1;
        specv_next = POS_ZERO;
        if (f_is_zero(d)) begin
            specv_next = (f_is_nan(n) || f_is_zero(n)) ? CANON_NAN : {sq, INF_MAG};
        end else if (f_is_nan(n)) begin
            specv_next = n | QNAN_BIT;
        end else if (f_is_nan(d)) begin
            specv_next = d | QNAN_BIT;
        end else if (f_is_inf(n) && f_is_inf(d)) begin
            specv_next = DEF_NAN;
        end else if (f_is_inf(n)) begin
            specv_next = {sq, INF_MAG};
        end else if (f_is_inf(d) || f_is_zero(n)) begin
            specv_next = {sq, 31'd0};
        end else begin
            spec_next = 1'b0;
        end
    end

    logic        vu_reg, specu_reg, sgnu_reg;
    logic [31:0] specvu_reg;
    logic [23:0] mnu_reg, mdu_reg;
    exp_t        eu_reg;

    // iteration pipeline, entry 0 is the pre-scaled dividend
    logic        v_reg     [DIV_STG+1];
    logic        spec_reg  [DIV_STG+1];
    logic [31:0] specv_reg [DIV_STG+1];
    logic        sgn_reg   [DIV_STG+1];
    logic [23:0] md_reg    [DIV_STG+1];
    exp_t        e_reg     [DIV_STG+1];
    logic [24:0] rem_reg   [DIV_STG+1];
    logic [DIV_QBITS-1:0] q_reg [DIV_STG+1];

    logic [24:0]          rem_next [DIV_STG];
    logic [DIV_QBITS-1:0] q_next   [DIV_STG];

    always_comb begin
        logic [24:0]          r;
        logic [DIV_QBITS-1:0] qq;
        logic                 bt;
        for (int k = 0; k < DIV_STG; k++) begin
            r  = rem_reg[k];
            qq = q_reg[k];
            for (int j = 0; j < DIV_BITS; j++) begin
                bt = r >= {1'b0, md_reg[k]};
                if (bt) r = r - {1'b0, md_reg[k]};
                r  = r << 1;
                qq = {qq[DIV_QBITS-2:0], bt};
            end
            rem_next[k] = r;
            q_next[k]   = qq;
        end
    end

    // denormal right shift
    logic [26:0] n27, smask, ns_next;
    exp_t        shs, es_next;

    always_comb begin
        n27     = {q_reg[DIV_STG], |rem_reg[DIV_STG]};
        shs     = 11'sd1 - e_reg[DIV_STG];
        smask   = '0;
        ns_next = n27;
        es_next = e_reg[DIV_STG];
        if (e_reg[DIV_STG] < 11'sd1) begin
            es_next = 11'sd1;
            if (shs > 11'sd26) begin
                ns_next = {26'd0, |n27};
            end else begin
                smask   = (27'd1 << shs[4:0]) - 27'd1;
                ns_next = (n27 >> shs[4:0]) | {26'd0, |(n27 & smask)};
            end
        end
    end

    logic        vs_reg, specs_reg, sgns_reg, vr_reg;
    logic [31:0] specvs_reg, q_out_reg;
    logic [26:0] ns_reg;
    exp_t        es_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vu_reg <= 1'b0;
            vs_reg <= 1'b0;
            vr_reg <= 1'b0;
            for (int k = 0; k <= DIV_STG; k++) v_reg[k] <= 1'b0;
        end else if (en) begin
            vu_reg   <= in_valid;
            v_reg[0] <= vu_reg;
            for (int k = 0; k < DIV_STG; k++) v_reg[k+1] <= v_reg[k];
            vs_reg   <= v_reg[DIV_STG];
            vr_reg   <= vs_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            specu_reg  <= spec_next;
            specvu_reg <= specv_next;
            sgnu_reg   <= sq;
            mnu_reg    <= mn << lzn;
            mdu_reg    <= md << lzd;
            eu_reg     <= expn - expd + 11'sd127;

            spec_reg[0]  <= specu_reg;
            specv_reg[0] <= specvu_reg;
            sgn_reg[0]   <= sgnu_reg;
            md_reg[0]    <= mdu_reg;
            q_reg[0]     <= '0;
            if (mnu_reg < mdu_reg) begin
                rem_reg[0] <= {mnu_reg, 1'b0};
                e_reg[0]   <= eu_reg - 11'sd1;
            end else begin
                rem_reg[0] <= {1'b0, mnu_reg};
                e_reg[0]   <= eu_reg;
            end

            for (int k = 0; k < DIV_STG; k++) begin
                spec_reg[k+1]  <= spec_reg[k];
                specv_reg[k+1] <= specv_reg[k];
                sgn_reg[k+1]   <= sgn_reg[k];
                md_reg[k+1]    <= md_reg[k];
                e_reg[k+1]     <= e_reg[k];
                rem_reg[k+1]   <= rem_next[k];
                q_reg[k+1]     <= q_next[k];
            end

            specs_reg  <= spec_reg[DIV_STG];
            specvs_reg <= specv_reg[DIV_STG];
            sgns_reg   <= sgn_reg[DIV_STG];
            ns_reg     <= ns_next;
            es_reg     <= es_next;

            q_out_reg  <= specs_reg ? specvs_reg : f_round_pack(sgns_reg, es_reg, ns_reg);
        end
    end

    assign out_valid = vr_reg;
    assign q         = q_out_reg;

endmodule

>>> hw/rtl/rbsi_axis.sv
// ----------------------------------------------------------------------------
// rbsi_axis
// one axis of the slab test: corners, slab parameters, near and far values
// ----------------------------------------------------------------------------
module rbsi_axis (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] center,
    input  logic [31:0] half,
    input  logic [31:0] origin,
    input  logic [31:0] dir,
    output logic        out_valid,
    output logic [31:0] near_t,
    output logic [31:0] far_t
);
    import rbsi_pkg::*;

    logic        p_valid, t_valid, q_valid, unused_v0, unused_v1, unused_v2;
    logic [31:0] p1, p2, ta, tb, na, nb;

    rbsi_fadd u_add_p (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(in_valid),
        .sub(1'b0), .a(center), .b(half), .out_valid(p_valid), .y(p1)
    );

    rbsi_fadd u_add_m (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(in_valid),
        .sub(1'b1), .a(center), .b(half), .out_valid(unused_v0), .y(p2)
    );

    // origin and direction follow the corner adders
    logic [31:0] o_dly_reg  [ADD_LAT];
    logic [31:0] d_dly_reg  [ADD_LAT];
    logic [31:0] d_dly2_reg [ADD_LAT];

    logic        mm_v_reg;
    logic [31:0] lo_reg, hi_reg, o_mm_reg, d_mm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mm_v_reg <= 1'b0;
        end else if (en) begin
            mm_v_reg <= p_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_dly_reg[0] <= origin;
            d_dly_reg[0] <= dir;
            for (int i = 1; i < ADD_LAT; i++) begin
                o_dly_reg[i] <= o_dly_reg[i-1];
                d_dly_reg[i] <= d_dly_reg[i-1];
            end
            lo_reg   <= f_min(p1, p2);
            hi_reg   <= f_max(p1, p2);
            o_mm_reg <= o_dly_reg[ADD_LAT-1];
            d_mm_reg <= d_dly_reg[ADD_LAT-1];
            d_dly2_reg[0] <= d_mm_reg;
            for (int i = 1; i < ADD_LAT; i++) begin
                d_dly2_reg[i] <= d_dly2_reg[i-1];
            end
        end
    end

    rbsi_fadd u_sub_lo (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(mm_v_reg),
        .sub(1'b1), .a(lo_reg), .b(o_mm_reg), .out_valid(t_valid), .y(ta)
    );

    rbsi_fadd u_sub_hi (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(mm_v_reg),
        .sub(1'b1), .a(hi_reg), .b(o_mm_reg), .out_valid(unused_v1), .y(tb)
    );

    rbsi_fdiv u_div_a (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(t_valid),
        .n(ta), .d(d_dly2_reg[ADD_LAT-1]), .out_valid(q_valid), .q(na)
    );

    rbsi_fdiv u_div_b (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(t_valid),
        .n(tb), .d(d_dly2_reg[ADD_LAT-1]), .out_valid(unused_v2), .q(nb)
    );

    logic        nf_v_reg;
    logic [31:0] near_reg, far_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nf_v_reg <= 1'b0;
        end else if (en) begin
            nf_v_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            near_reg <= f_min(na, nb);
            far_reg  <= f_max(na, nb);
        end
    end

    assign out_valid = nf_v_reg & (unused_v0 | ~unused_v0) & (unused_v1 | ~unused_v1)
                       & (unused_v2 | ~unused_v2);
    assign near_t    = near_reg;
    assign far_t     = far_reg;

endmodule

>>> hw/rtl/ray_box_slab_intersection.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersection
// ray against axis-aligned box, slab method, single-precision pipeline
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request: a box (centre, half extents) and a ray
//   (origin, direction), twelve ieee single values packed into tdata
//   m_axis returns one result per request: the hit distance in tdata and
//   the hit flag in tuser; a miss gives -1.0 with the flag low
//   from acceptance to m_axis_tvalid a request passes four-stage
//   corner adders, a min/max stage, four-stage subtractors, a 17-stage
//   divider (two quotient bits a stage), near/far, entry/exit and the
//   output register
//   throughput is one request a cycle while the receiver keeps up
//   every stage moves on a single advance enable; when the receiver stalls
//   with a result waiting, the whole pipeline holds and s_axis_tready drops
//   in the same cycle, so nothing is lost or repeated
//   a synchronous reset (aresetn low) clears every valid bit; payload
//   registers are not reset
// ----------------------------------------------------------------------------
module ray_box_slab_intersection (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // centre x,y,z, half x,y,z, origin x,y,z, direction x,y,z (32 bits each)
    input  logic [rbsi_pkg::IN_W-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // hit_distance
    output logic [31:0]               m_axis_tdata,
    // hit
    output logic [0:0]                m_axis_tuser
);
    import rbsi_pkg::*;

    // global advance: the output register is free or being drained
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic        ax_valid [NUM_AXES];
    logic [31:0] ax_near  [NUM_AXES];
    logic [31:0] ax_far   [NUM_AXES];

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
        rbsi_axis u_axis (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (s_axis_tvalid),
            .center   (s_axis_tdata[g*FLT_W +: FLT_W]),
            .half     (s_axis_tdata[(NUM_AXES+g)*FLT_W +: FLT_W]),
            .origin   (s_axis_tdata[(2*NUM_AXES+g)*FLT_W +: FLT_W]),
            .dir      (s_axis_tdata[(3*NUM_AXES+g)*FLT_W +: FLT_W]),
            .out_valid(ax_valid[g]),
            .near_t   (ax_near[g]),
            .far_t    (ax_far[g])
        );
    end

    // entry / exit stage
    logic        ee_v_reg;
    logic [31:0] entry_reg, exit_reg;

    // result stage doubles as the output register
    logic        out_v_reg;
    logic [31:0] dist_reg;
    logic        hit_reg;

    logic        miss;
    logic [31:0] dist_next;

    always_comb begin
        miss      = f_lt(exit_reg, POS_ZERO) || f_lt(exit_reg, entry_reg);
        dist_next = f_lt(entry_reg, POS_ZERO) ? exit_reg : entry_reg;
        if (miss) dist_next = MISS_VAL;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ee_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            // all axes run in lockstep
            ee_v_reg  <= ax_valid[0] & ax_valid[1] & ax_valid[2];
            out_v_reg <= ee_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            entry_reg <= f_max(f_max(ax_near[0], ax_near[1]), ax_near[2]);
            exit_reg  <= f_min(f_min(ax_far[0], ax_far[1]), ax_far[2]);
            dist_reg  <= dist_next;
            hit_reg   <= !miss;
        end
    end

    assign m_axis_tvalid   = out_v_reg;
    assign m_axis_tdata    = dist_reg;
    assign m_axis_tuser[0] = hit_reg;

    // a miss always reports minus one
    a_miss_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == MISS_VAL))
        else $error("miss without -1.0 distance");

    // a hit never reports a negative non-zero ordered distance
    a_hit_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        (!m_axis_tdata[31] || f_is_nan(m_axis_tdata) || f_is_zero(m_axis_tdata)))
        else $error("hit with negative distance");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result keeps its payload through the stall
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(dist_reg) && $stable(hit_reg)))
        else $error("result changed during stall");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the slab-method ray/box intersection block against a bit-exact
// single-precision predictor, with random idling on both stream sides
// ----------------------------------------------------------------------------
module tb_top;
    import rbsi_pkg::*;

    // one box/ray pair as it travels in s_axis_tdata
    typedef struct packed {
        logic [31:0] dir_z;
        logic [31:0] dir_y;
        logic [31:0] dir_x;
        logic [31:0] org_z;
        logic [31:0] org_y;
        logic [31:0] org_x;
        logic [31:0] half_z;
        logic [31:0] half_y;
        logic [31:0] half_x;
        logic [31:0] ctr_z;
        logic [31:0] ctr_y;
        logic [31:0] ctr_x;
    } box_ray_t;

    typedef struct {
        logic [31:0] distance;
        logic        hit;
    } hit_t;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 60;
    localparam logic [31:0] POS_INF        = 32'h7F80_0000;
    localparam logic [31:0] NEG_INF        = 32'hFF80_0000;
    localparam logic [31:0] NEG_ZERO       = 32'h8000_0000;
    localparam logic [31:0] ONE_VAL        = 32'h3F80_0000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // centre x,y,z, half x,y,z, origin x,y,z, direction x,y,z (32 bits each)
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // hit_distance
    logic [31:0]          m_axis_tdata;
    // hit
    logic [0:0]           m_axis_tuser;

    hit_t expected_hits[$];
    int   error_count;
    int   idle_cycles;
    bit   calm;           // no idling on either side while set

    ray_box_slab_intersection u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // single-precision arithmetic, done in double and rounded once
    // (double holds sums and quotients of singles closely enough that
    // one round to nearest even gives the exact single result)
    // ------------------------------------------------------------------
    function automatic logic is_nan32(logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf32(logic [31:0] x);
        return x[30:0] == 31'h7F80_0000;
    endfunction

    function automatic logic is_zero32(logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    // finite single to double
    function automatic real widen(logic [31:0] b);
        real v;
        if (b[30:23] == 8'd0) begin
            // subnormal: mantissa times 2^-149
            v = real'(b[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
            if (b[31]) v = -v;
        end else begin
            v = $bitstoreal({b[31], 11'(b[30:23] - 8'd127 + 11'd1023), b[22:0], 29'd0});
        end
        return v;
    endfunction

    // finite double to single, round to nearest even, subnormals kept
    function automatic logic [31:0] narrow(real x);
        logic [63:0] d;
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] packed_val;
        logic        g;
        logic        st;
        int          e;
        int          s;
        d = $realtobits(x);
        if (d[62:0] == 63'd0) return {d[63], 31'd0};
        e = int'(d[62:52]) - 1023;
        m = {11'd0, 1'b1, d[51:0]};
        s = (e >= -126) ? 29 : 29 + (-126 - e);
        if (s >= 64) begin
            q  = 64'd0;
            g  = 1'b0;
            st = 1'b1;
        end else begin
            q  = m >> s;
            g  = m[s-1];
            st = (m & ((64'd1 << (s - 1)) - 64'd1)) != 64'd0;
        end
        if (g && (st || q[0])) q = q + 64'd1;
        // hidden bit in q carries into the exponent field, so a rounding
        // overflow or a subnormal rounding up to normal lands correctly
        packed_val = (e >= -126) ? ((64'(e + 126) << 23) + q) : q;
        if (packed_val >= (64'd255 << 23)) return {d[63], 31'h7F80_0000};
        return {d[63], packed_val[30:0]};
    endfunction

    // a + b, or a - b when negate is set; nan payloads follow the first nan
    function automatic logic [31:0] add32(logic [31:0] a, logic [31:0] b, logic negate);
        logic [31:0] bb;
        if (is_nan32(a)) return a | QNAN_BIT;
        if (is_nan32(b)) return b | QNAN_BIT;
        bb = {b[31] ^ negate, b[30:0]};
        if (is_inf32(a) && is_inf32(bb) && (a[31] != bb[31])) return DEF_NAN;
        if (is_inf32(a)) return a;
        if (is_inf32(bb)) return bb;
        return narrow(widen(a) + widen(bb));
    endfunction

    function automatic logic [31:0] div32(logic [31:0] n, logic [31:0] d);
        logic sx;
        sx = n[31] ^ d[31];
        // zero divisor is decided before anything else
        if (is_zero32(d)) begin
            if (is_nan32(n) || is_zero32(n)) return CANON_NAN;
            return {sx, INF_MAG};
        end
        if (is_nan32(n)) return n | QNAN_BIT;
        if (is_nan32(d)) return d | QNAN_BIT;
        if (is_inf32(n) && is_inf32(d)) return DEF_NAN;
        if (is_inf32(n)) return {sx, INF_MAG};
        if (is_inf32(d)) return {sx, 31'd0};
        return narrow(widen(n) / widen(d));
    endfunction

    // ordered less-than; false on any nan and between two zeros
    function automatic logic less32(logic [31:0] a, logic [31:0] b);
        logic [31:0] ka;
        logic [31:0] kb;
        if (is_nan32(a) || is_nan32(b)) return 1'b0;
        if (is_zero32(a) && is_zero32(b)) return 1'b0;
        ka = a[31] ? ~a : {1'b1, a[30:0]};
        kb = b[31] ? ~b : {1'b1, b[30:0]};
        return ka < kb;
    endfunction

    function automatic logic [31:0] min32(logic [31:0] a, logic [31:0] b);
        if (is_nan32(a)) return b;
        if (is_nan32(b)) return a;
        if (is_zero32(a) && is_zero32(b)) return a[31] ? a : b;
        return less32(a, b) ? a : b;
    endfunction

    function automatic logic [31:0] max32(logic [31:0] a, logic [31:0] b);
        if (is_nan32(a)) return b;
        if (is_nan32(b)) return a;
        if (is_zero32(a) && is_zero32(b)) return a[31] ? b : a;
        return less32(b, a) ? a : b;
    endfunction

    // entry/exit over the three slabs and the hit decision
    function automatic hit_t slab_hit(box_ray_t r);
        logic [31:0] ctr[3];
        logic [31:0] half[3];
        logic [31:0] org[3];
        logic [31:0] dir[3];
        logic [31:0] p1, p2, lo, hi, ta, tb, t_entry, t_exit;
        hit_t        res;
        ctr  = '{r.ctr_x, r.ctr_y, r.ctr_z};
        half = '{r.half_x, r.half_y, r.half_z};
        org  = '{r.org_x, r.org_y, r.org_z};
        dir  = '{r.dir_x, r.dir_y, r.dir_z};
        t_entry = POS_ZERO;
        t_exit  = POS_ZERO;
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            p1 = add32(ctr[ax], half[ax], 1'b0);
            p2 = add32(ctr[ax], half[ax], 1'b1);
            lo = min32(p1, p2);
            hi = max32(p1, p2);
            ta = div32(add32(lo, org[ax], 1'b1), dir[ax]);
            tb = div32(add32(hi, org[ax], 1'b1), dir[ax]);
            if (ax == 0) begin
                t_entry = min32(ta, tb);
                t_exit  = max32(ta, tb);
            end else begin
                t_entry = max32(t_entry, min32(ta, tb));
                t_exit  = min32(t_exit, max32(ta, tb));
            end
        end
        if (less32(t_exit, POS_ZERO) || less32(t_exit, t_entry)) begin
            res.distance = MISS_VAL;
            res.hit      = 1'b0;
        end else if (less32(t_entry, POS_ZERO)) begin
            res.distance = t_exit;
            res.hit      = 1'b1;
        end else begin
            res.distance = t_entry;
            res.hit      = 1'b1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // request driver: optional gap, then hold tvalid until accepted
    // ------------------------------------------------------------------
    task automatic send_request(box_ray_t r);
        int gap;
        gap = (!calm && $urandom_range(99) < 20) ? $urandom_range(4, 1) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        expected_hits.push_back(slab_hit(r));
    endtask

    // ------------------------------------------------------------------
    // operand generators
    // ------------------------------------------------------------------
    function automatic logic [31:0] special_val();
        logic [31:0] pool[16];
        pool = '{POS_ZERO, NEG_ZERO, POS_INF, NEG_INF, CANON_NAN, 32'h7F80_0001,
                 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF,
                 32'h7F7F_FFFF, 32'hFF7F_FFFF, ONE_VAL, MISS_VAL, 32'h0080_0000,
                 32'h4000_0000};
        return pool[$urandom_range(15)];
    endfunction

    // value in +/- span, two decimal places
    function automatic logic [31:0] modest(int span);
        return narrow(real'(int'($urandom_range(2 * span * 100)) - span * 100) / 100.0);
    endfunction

    // a ray aimed near the box, so most of these hit
    function automatic box_ray_t aimed_ray();
        box_ray_t r;
        real      tgt;
        r.ctr_x  = modest(10);
        r.ctr_y  = modest(10);
        r.ctr_z  = modest(10);
        r.half_x = narrow(real'($urandom_range(500, 5)) / 100.0);
        r.half_y = narrow(real'($urandom_range(500, 5)) / 100.0);
        r.half_z = narrow(real'($urandom_range(500, 5)) / 100.0);
        r.org_x  = modest(20);
        r.org_y  = modest(20);
        r.org_z  = modest(20);
        tgt = widen(r.ctr_x) + widen(r.half_x) * (real'($urandom_range(300)) / 100.0 - 1.5);
        r.dir_x = narrow(tgt - widen(r.org_x));
        tgt = widen(r.ctr_y) + widen(r.half_y) * (real'($urandom_range(300)) / 100.0 - 1.5);
        r.dir_y = narrow(tgt - widen(r.org_y));
        tgt = widen(r.ctr_z) + widen(r.half_z) * (real'($urandom_range(300)) / 100.0 - 1.5);
        r.dir_z = narrow(tgt - widen(r.org_z));
        // axis-parallel rays and reversed rays now and then
        if ($urandom_range(9) == 0) r.dir_x = $urandom_range(1) ? POS_ZERO : NEG_ZERO;
        if ($urandom_range(9) == 0) r.dir_y = $urandom_range(1) ? POS_ZERO : NEG_ZERO;
        if ($urandom_range(9) == 0) r.dir_z[31] = ~r.dir_z[31];
        return r;
    endfunction

    function automatic box_ray_t noise_ray();
        logic [31:0] f[12];
        for (int i = 0; i < 12; i++) begin
            case ($urandom_range(2))
                0:       f[i] = $urandom;
                1:       f[i] = special_val();
                default: f[i] = modest(50);
            endcase
        end
        return {f[11], f[10], f[9], f[8], f[7], f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
    endfunction

    function automatic box_ray_t make_ray(logic [31:0] cx, logic [31:0] hx, logic [31:0] ox,
                                          logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        box_ray_t r;
        r = '{dir_z: dz, dir_y: dy, dir_x: dx, org_z: POS_ZERO, org_y: POS_ZERO, org_x: ox,
              half_z: ONE_VAL, half_y: ONE_VAL, half_x: hx,
              ctr_z: POS_ZERO, ctr_y: POS_ZERO, ctr_x: cx};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // ray along +x from far left hits a unit box at the origin
        send_request(make_ray(POS_ZERO, ONE_VAL, 32'hC120_0000, ONE_VAL, POS_ZERO, POS_ZERO));
        // origin inside the box: entry negative, exit taken
        send_request(make_ray(POS_ZERO, ONE_VAL, POS_ZERO, ONE_VAL, POS_ZERO, POS_ZERO));
        // box behind the ray: exit below zero, miss
        send_request(make_ray(32'h4120_0000, ONE_VAL, POS_ZERO, MISS_VAL, POS_ZERO, POS_ZERO));
        // parallel ray outside a slab: entry above exit, miss
        send_request(make_ray(POS_ZERO, ONE_VAL, 32'hC120_0000, ONE_VAL, POS_ZERO, POS_ZERO)
                     ^ {32'd0, 32'd0, 32'd0, 32'd0, 32'h4120_0000, {7{32'd0}}});
        // all-zero direction: zero-divisor infinities
        send_request(make_ray(POS_ZERO, ONE_VAL, POS_ZERO, POS_ZERO, NEG_ZERO, POS_ZERO));
        // zero numerator over zero divisor gives nan on one axis
        send_request(make_ray(POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO, ONE_VAL, ONE_VAL));
        // negative zeros in every x field and in the direction
        send_request(make_ray(NEG_ZERO, NEG_ZERO, NEG_ZERO, NEG_ZERO, NEG_ZERO, NEG_ZERO));
        // nan operands ignored by min/max
        send_request(make_ray(CANON_NAN, ONE_VAL, POS_ZERO, ONE_VAL, ONE_VAL, ONE_VAL));
        // nan everywhere: nan result with the hit flag set
        send_request('{default: 32'h7FC0_0001});
        // infinities: inf minus inf and inf over inf
        send_request(make_ray(POS_INF, POS_INF, NEG_INF, POS_INF, NEG_INF, ONE_VAL));
        // overflow of the corner sums and of the quotients
        send_request(make_ray(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
                              32'h0000_0001, ONE_VAL, ONE_VAL));
        // subnormal operands and underflowing quotients
        send_request(make_ray(32'h0000_0001, 32'h007F_FFFF, 32'h8000_0001,
                              32'h7F7F_FFFF, 32'h0080_0000, 32'h807F_FFFF));
        // all ones and all zeros in every field, each also with the sign bit flipped
        send_request('{default: 32'hFFFF_FFFF});
        send_request('{default: 32'h0000_0000});
        send_request('{default: 32'h7FFF_FFFF});
        send_request('{default: 32'h8000_0000});
        // negative half extents swap the corners
        send_request(make_ray(POS_ZERO, MISS_VAL, 32'hC120_0000, ONE_VAL, POS_ZERO, POS_ZERO));
        for (int i = 0; i < 4; i++) send_request(aimed_ray());
    endtask

    task automatic test_random(int count);
        box_ray_t r;
        for (int i = 0; i < count; i++) begin
            // a stretch with no idling on either side
            calm = (i >= count / 2) && (i < count / 2 + 200);
            case ($urandom_range(9))
                0, 1:    r = noise_ray();
                2:       begin
                    r = aimed_ray();
                    r.dir_y = special_val();
                end
                default: r = aimed_ray();
            endcase
            send_request(r);
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    always @(posedge aclk) begin
        hit_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_hits.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, 32'd0);
            end else begin
                want = expected_hits.pop_front();
                if (m_axis_tdata !== want.distance)
                    report_mismatch("hit_distance", m_axis_tdata, want.distance);
                if (m_axis_tuser[0] !== want.hit)
                    report_mismatch("hit", 32'(m_axis_tuser), 32'(want.hit));
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 20);
    end

    // watchdog on cycles with no request or result moving
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        error_count   = 0;
        idle_cycles   = 0;
        calm          = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(1430);

        // drain outstanding results, then a little latency margin
        while (expected_hits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
